@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/csem_pkg.sv @@
// Shared types, codes and width helpers for the counting semaphore.
`default_nettype none
package csem_pkg;

  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_INITIAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX     = 8'd1;

  localparam logic [1:0] ACT_WAIT   = 2'd0;
  localparam logic [1:0] ACT_SIGNAL = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_WOKEN    = 3'd2;
  localparam logic [2:0] ST_RAISED   = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  typedef enum logic [1:0] {
    QOP_PUSH   = 2'd0,
    QOP_POP    = 2'd1,
    QOP_REMOVE = 2'd2
  } qop_t;

  typedef struct packed {
    logic go;
    qop_t op;
  } q_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } q_rsp_t;

  function automatic int addr_bits(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic int len_bits(int depth);
    return $clog2(depth + 1);
  endfunction

endpackage
`default_nettype wire

@@ src/csem_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [csem_pkg::addr_bits(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [csem_pkg::addr_bits(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  import csem_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ src/csem_queue.sv @@
// Circular wait queue with push, pop and remove-by-id sequencer.
`default_nettype none
module csem_queue #(
  parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH,
  parameter int ID_BITS     = csem_pkg::ID_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  csem_pkg::q_req_t                         req,
  input  logic [ID_BITS-1:0]                       id,
  output csem_pkg::q_rsp_t                         rsp,
  output logic [ID_BITS-1:0]                       pop_id,
  output logic [csem_pkg::len_bits(QUEUE_DEPTH)-1:0] len
);
  import csem_pkg::*;

  localparam int AW = addr_bits(QUEUE_DEPTH);
  localparam int LW = len_bits(QUEUE_DEPTH);
  localparam int SW = LW + 1;

  typedef enum logic [4:0] {
    Q_IDLE = 5'b00001,
    Q_POP  = 5'b00010,
    Q_CMP  = 5'b00100,
    Q_SHRD = 5'b01000,
    Q_SHWR = 5'b10000
  } qstate_t;

  qstate_t           state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [LW-1:0]     k_r, k_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [ID_BITS-1:0] pop_id_r, pop_id_nxt;
  logic              done_r, done_nxt;
  logic              found_r, found_nxt;

  logic [LW-1:0]      kp1;
  logic [LW-1:0]      off;
  logic [SW-1:0]      sum;
  logic [AW-1:0]      pos;
  logic               we;
  logic [ID_BITS-1:0] wdata;
  logic [ID_BITS-1:0] rdata;

  csem_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(pos),
    .wdata(wdata),
    .raddr(pos),
    .rdata(rdata)
  );

  assign kp1 = k_r + LW'(1);

  // Shared address unit: head plus offset, wrapped at the queue depth.
  always_comb begin
    off = '0;
    unique case (state_r)
      Q_IDLE: if (req.go && req.op == QOP_PUSH) off = len_r;
      Q_POP:  off = LW'(1);
      Q_CMP:  off = kp1;
      Q_SHRD: off = kp1;
      Q_SHWR: off = k_r;
      default: off = '0;
    endcase
    sum = SW'(head_r) + SW'(off);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    pos = sum[AW-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    len_nxt    = len_r;
    k_nxt      = k_r;
    id_nxt     = id_r;
    pop_id_nxt = pop_id_r;
    done_nxt   = 1'b0;
    found_nxt  = 1'b0;
    we         = 1'b0;
    wdata      = id;
    unique case (state_r)
      Q_IDLE: begin
        if (req.go) begin
          unique case (req.op)
            QOP_PUSH: begin
              we       = 1'b1;
              len_nxt  = len_r + LW'(1);
              done_nxt = 1'b1;
            end
            QOP_POP: state_nxt = Q_POP;
            QOP_REMOVE: begin
              id_nxt    = id;
              k_nxt     = '0;
              state_nxt = Q_CMP;
            end
            default: state_nxt = Q_IDLE;
          endcase
        end
      end
      Q_POP: begin
        pop_id_nxt = rdata;
        head_nxt   = pos;
        len_nxt    = len_r - LW'(1);
        done_nxt   = 1'b1;
        state_nxt  = Q_IDLE;
      end
      Q_CMP: begin
        if (rdata == id_r) begin
          if (kp1 >= len_r) begin
            len_nxt   = len_r - LW'(1);
            done_nxt  = 1'b1;
            found_nxt = 1'b1;
            state_nxt = Q_IDLE;
          end else begin
            state_nxt = Q_SHWR;
          end
        end else if (kp1 >= len_r) begin
          done_nxt  = 1'b1;
          state_nxt = Q_IDLE;
        end else begin
          k_nxt = kp1;
        end
      end
      Q_SHRD: begin
        if (kp1 >= len_r) begin
          len_nxt   = len_r - LW'(1);
          done_nxt  = 1'b1;
          found_nxt = 1'b1;
          state_nxt = Q_IDLE;
        end else begin
          state_nxt = Q_SHWR;
        end
      end
      Q_SHWR: begin
        we        = 1'b1;
        wdata     = rdata;
        k_nxt     = kp1;
        state_nxt = Q_SHRD;
      end
      default: state_nxt = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Q_IDLE;
      head_r  <= '0;
      len_r   <= '0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      len_r   <= len_nxt;
      done_r  <= done_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    id_r     <= id_nxt;
    pop_id_r <= pop_id_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.found = found_r;
  assign pop_id    = pop_id_r;
  assign len       = len_r;

endmodule
`default_nettype wire

@@ src/counting_semaphore_fifo_waitq.sv @@
// Counting semaphore with ceiling and FIFO wait queue, top level.
// Grant, raise, full and no-op beats are registered straight from the accept into the output
// register; a queued wait, a wake and a remove run the queue sequencer, a remove comparing
// entries from the head, then moving each later entry down. One beat in flight: the next beat
// is taken once the last result is in the output register, later while it waits behind a stall.
// Reset: count 0, ceiling 65535, queue empty; queue RAM is not cleared (no clearing pass).
`default_nettype none
`include "assert_macros.svh"
module counting_semaphore_fifo_waitq #(
  parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH,
  parameter int ID_BITS     = csem_pkg::ID_BITS
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // input channel
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [1:0]                                 in_action,
  input  logic [ID_BITS-1:0]                         in_proc_id,
  // result channel
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [2:0]                                 out_status,
  output logic [ID_BITS-1:0]                         out_woken_id,
  output logic [csem_pkg::CNT_W-1:0]                 out_count_now,
  output logic [csem_pkg::len_bits(QUEUE_DEPTH)-1:0] out_waiters_now,
  // configuration write channel
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [csem_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [csem_pkg::CNT_W-1:0]                 cfg_data
);
  import csem_pkg::*;

  localparam int LW = len_bits(QUEUE_DEPTH);

  // IDLE: ready for a beat. RUN: queue sequencer busy.
  // PEND: result held because the output register is still occupied.
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_PEND = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] max_r, max_nxt;
  logic [2:0]       stat_r, stat_nxt;   // status promised to the queued op

  // pending result slot
  logic [2:0]         pend_status_r, pend_status_nxt;
  logic [ID_BITS-1:0] pend_woken_r, pend_woken_nxt;
  logic [CNT_W-1:0]   pend_count_r, pend_count_nxt;
  logic [LW-1:0]      pend_len_r, pend_len_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [ID_BITS-1:0] out_woken_r, out_woken_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;
  logic [LW-1:0]      out_len_r, out_len_nxt;

  q_req_t             q_req;
  q_rsp_t             q_rsp;
  logic [ID_BITS-1:0] q_pop_id;
  logic [LW-1:0]      q_len;

  logic               in_accept;
  logic               cfg_we;
  logic               out_free;
  logic               res_vld;
  logic [2:0]         res_status;
  logic [ID_BITS-1:0] res_woken;

  csem_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (q_req),
    .id    (in_proc_id),
    .rsp   (q_rsp),
    .pop_id(q_pop_id),
    .len   (q_len)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    max_nxt    = max_r;
    stat_nxt   = stat_r;
    q_req.go   = 1'b0;
    q_req.op   = QOP_PUSH;
    res_vld    = 1'b0;
    res_status = ST_NOTFOUND;
    res_woken  = '0;

    // Register writes must be made only while idle (not enforced here); bad indexes drop out.
    if (cfg_we) begin
      if (cfg_index == REG_INITIAL) begin
        if (cfg_data <= max_r) count_nxt = cfg_data;
      end else if (cfg_index == REG_MAX) begin
        if (cfg_data >= count_r) max_nxt = cfg_data;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_action)
            ACT_WAIT: begin
              if (count_r != '0) begin
                // units left: grant even with waiters queued
                count_nxt  = count_r - CNT_W'(1);
                res_vld    = 1'b1;
                res_status = ST_GRANTED;
              end else if (q_len == LW'(QUEUE_DEPTH)) begin
                res_vld    = 1'b1;
                res_status = ST_FULL;
              end else begin
                q_req.go  = 1'b1;
                q_req.op  = QOP_PUSH;
                stat_nxt  = ST_QUEUED;
                state_nxt = S_RUN;
              end
            end
            ACT_SIGNAL: begin
              if (q_len == '0) begin
                // no waiter: raise, saturating at the ceiling
                if (count_r < max_r) count_nxt = count_r + CNT_W'(1);
                res_vld    = 1'b1;
                res_status = ST_RAISED;
              end else begin
                q_req.go  = 1'b1;
                q_req.op  = QOP_POP;
                stat_nxt  = ST_WOKEN;
                state_nxt = S_RUN;
              end
            end
            ACT_REMOVE: begin
              if (q_len == '0) begin
                res_vld    = 1'b1;
                res_status = ST_NOTFOUND;
              end else begin
                q_req.go  = 1'b1;
                q_req.op  = QOP_REMOVE;
                stat_nxt  = ST_REMOVED;
                state_nxt = S_RUN;
              end
            end
            default: begin
              // unused action code: no-op reported as not found
              res_vld    = 1'b1;
              res_status = ST_NOTFOUND;
            end
          endcase
        end
      end
      S_RUN: begin
        if (q_rsp.done) begin
          res_vld    = 1'b1;
          res_status = (stat_r == ST_REMOVED && !q_rsp.found) ? ST_NOTFOUND : stat_r;
          res_woken  = (stat_r == ST_WOKEN) ? q_pop_id : '0;
        end
      end
      S_PEND: begin
        state_nxt = S_PEND;
      end
      default: state_nxt = S_IDLE;
    endcase

    // Result routing: straight into the output register when it is free,
    // else park it in the pending slot.
    pend_status_nxt = pend_status_r;
    pend_woken_nxt  = pend_woken_r;
    pend_count_nxt  = pend_count_r;
    pend_len_nxt    = pend_len_r;
    out_status_nxt  = out_status_r;
    out_woken_nxt   = out_woken_r;
    out_count_nxt   = out_count_r;
    out_len_nxt     = out_len_r;
    out_valid_nxt   = out_valid_r && out_stall;

    if (res_vld) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = res_status;
        out_woken_nxt  = res_woken;
        out_count_nxt  = count_nxt;
        out_len_nxt    = q_len;
        state_nxt      = S_IDLE;
      end else begin
        pend_status_nxt = res_status;
        pend_woken_nxt  = res_woken;
        pend_count_nxt  = count_nxt;
        pend_len_nxt    = q_len;
        state_nxt       = S_PEND;
      end
    end else if (state_r == S_PEND && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = pend_status_r;
      out_woken_nxt  = pend_woken_r;
      out_count_nxt  = pend_count_r;
      out_len_nxt    = pend_len_r;
      state_nxt      = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      max_r       <= {CNT_W{1'b1}};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r        <= stat_nxt;
    pend_status_r <= pend_status_nxt;
    pend_woken_r  <= pend_woken_nxt;
    pend_count_r  <= pend_count_nxt;
    pend_len_r    <= pend_len_nxt;
    out_status_r  <= out_status_nxt;
    out_woken_r   <= out_woken_nxt;
    out_count_r   <= out_count_nxt;
    out_len_r     <= out_len_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_woken_id    = out_woken_r;
  assign out_count_now   = out_count_r;
  assign out_waiters_now = out_len_r;

  // queue answers only while an op is outstanding
  `ASSERT_IMPL(a_done_in_run, clk, rst_n, q_rsp.done, state_r == S_RUN, "queue done outside RUN")
  // a parked result implies the output register is occupied
  `ASSERT_IMPL(a_pend_out_busy, clk, rst_n, state_r == S_PEND, out_valid_r, "PEND with free output")
  // count never above the ceiling
  `ASSERT_IMPL(a_count_ceiling, clk, rst_n, 1'b1, count_r <= max_r, "count above max_count")
  // a queue op starts only from IDLE and leaves the block busy
  `ASSERT_NEXT(a_go_busy, clk, rst_n, q_req.go, state_r == S_RUN, "queue op did not enter RUN")

endmodule
`default_nettype wire

@@ bench/semaphore_checker.sv @@
// Result checker for the counting semaphore: tracks requests, predicts and compares results.
`timescale 1ns / 100ps
module semaphore_checker (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 in_valid,
  input  logic                                                 in_stall,
  input  logic [1:0]                                           in_action,
  input  logic [csem_pkg::ID_BITS-1:0]                         in_proc_id,
  input  logic                                                 out_valid,
  input  logic                                                 out_stall,
  input  logic [2:0]                                           out_status,
  input  logic [csem_pkg::ID_BITS-1:0]                         out_woken_id,
  input  logic [csem_pkg::CNT_W-1:0]                           out_count_now,
  input  logic [csem_pkg::len_bits(csem_pkg::QUEUE_DEPTH)-1:0] out_waiters_now,
  input  logic                                                 cfg_valid,
  input  logic                                                 cfg_ready,
  input  logic [csem_pkg::CFG_IDX_W-1:0]                       cfg_index,
  input  logic [csem_pkg::CNT_W-1:0]                           cfg_data,
  output int                                                   pending_cnt,
  output int                                                   fail_cnt,
  output logic [7:0]                                           status_seen
);
  import csem_pkg::*;

  localparam int ID_W      = ID_BITS;
  localparam int LEN_W     = len_bits(QUEUE_DEPTH);
  localparam int DUE_DEPTH = 8;   // results in flight never exceed two beats

  typedef struct packed {
    logic [2:0]       status;
    logic [ID_W-1:0]  woken;
    logic [CNT_W-1:0] count;
    logic [LEN_W-1:0] waiters;
  } sem_result_t;

  // Semaphore image
  logic [CNT_W-1:0] sem_cnt;
  logic [CNT_W-1:0] sem_ceiling;
  logic [CNT_W-1:0] sem_init;
  logic [ID_W-1:0]  wait_ids [QUEUE_DEPTH];
  int               wait_len;

  // Predicted results, oldest at due_head
  sem_result_t due_buf [DUE_DEPTH];
  int          due_head;
  int          due_cnt;
  sem_result_t want;
  int          err_cnt = 0;

  function automatic sem_result_t sem_call(input logic [1:0] act, input logic [ID_W-1:0] id);
    sem_result_t r;
    int          hit;
    int          k;
    r        = '0;
    r.status = ST_NOTFOUND;
    hit      = -1;
    case (act)
      ACT_WAIT: begin
        if (sem_cnt != '0) begin
          sem_cnt  = sem_cnt - CNT_W'(1);
          r.status = ST_GRANTED;
        end else if (wait_len >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          wait_ids[wait_len] = id;
          wait_len++;
          r.status = ST_QUEUED;
        end
      end
      ACT_SIGNAL: begin
        if (wait_len == 0) begin
          if (sem_cnt < sem_ceiling) sem_cnt = sem_cnt + CNT_W'(1);
          r.status = ST_RAISED;
        end else begin
          r.woken = wait_ids[0];
          for (k = 1; k < wait_len; k++) wait_ids[k-1] = wait_ids[k];
          wait_len--;
          r.status = ST_WOKEN;
        end
      end
      ACT_REMOVE: begin
        for (k = 0; k < wait_len; k++) begin
          if (hit < 0 && wait_ids[k] == id) hit = k;
        end
        if (hit >= 0) begin
          for (k = hit + 1; k < wait_len; k++) wait_ids[k-1] = wait_ids[k];
          wait_len--;
          r.status = ST_REMOVED;
        end
      end
      default: ;  // unused action code: reported as not found
    endcase
    r.count   = sem_cnt;
    r.waiters = LEN_W'(wait_len);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sem_init    = '0;
      sem_ceiling = '1;
      sem_cnt     = '0;
      wait_len    = 0;
      due_head    = 0;
      due_cnt     = 0;
      status_seen <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_INITIAL) begin
          sem_init = cfg_data;
          if (cfg_data <= sem_ceiling) sem_cnt = cfg_data;
        end else if (cfg_index == REG_MAX) begin
          if (cfg_data >= sem_cnt) sem_ceiling = cfg_data;
        end
      end
      // A result beat never belongs to a request taken at the same edge
      if (out_valid && !out_stall) begin
        status_seen[out_status] <= 1'b1;
        if (due_cnt == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat, expected none, got status %0d count %0d",
                   $time, out_status, out_count_now);
        end else begin
          want     = due_buf[due_head];
          due_head = (due_head + 1) % DUE_DEPTH;
          due_cnt--;
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("woken_id", 32'(want.woken), 32'(out_woken_id));
          check_field("count_now", 32'(want.count), 32'(out_count_now));
          check_field("waiters_now", 32'(want.waiters), 32'(out_waiters_now));
        end
      end
      if (in_valid && !in_stall) begin
        if (due_cnt >= DUE_DEPTH) begin
          err_cnt++;
          $display("%0t: too many results outstanding, expected at most %0d, got %0d",
                   $time, DUE_DEPTH, due_cnt + 1);
        end else begin
          due_buf[(due_head + due_cnt) % DUE_DEPTH] = sem_call(in_action, in_proc_id);
          due_cnt++;
        end
      end
    end
    pending_cnt <= due_cnt;
    fail_cnt    <= err_cnt;
  end

endmodule

@@ bench/tb_counting_semaphore_fifo_waitq.sv @@
// Testbench top for the counting semaphore: stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps
module tb_counting_semaphore_fifo_waitq;
  import csem_pkg::*;

  localparam int LEN_W      = len_bits(QUEUE_DEPTH);
  localparam int LONG_HOLD  = 300;        // receiver hold-off, in cycles
  localparam int TIMEOUT_NS = 4_000_000;  // many times the slowest legal run

  // Action code the block treats as a no-op; not in the package
  localparam logic [1:0]           ACT_NOP      = 2'd3;
  // Register index with nothing behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_action  = ACT_WAIT;
  logic [ID_BITS-1:0]   in_proc_id = '0;
  logic                 out_valid;
  logic                 out_stall  = 1'b0;
  logic [2:0]           out_status;
  logic [ID_BITS-1:0]   out_woken_id;
  logic [CNT_W-1:0]     out_count_now;
  logic [LEN_W-1:0]     out_waiters_now;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CNT_W-1:0]     cfg_data   = '0;

  int         pending_cnt;
  int         fail_cnt;
  logic [7:0] status_seen;

  int beats_sent = 0;
  int cfg_writes = 0;
  int hold_req   = 0;  // bumped by the stimulus to ask for a long receiver hold-off

  // Receiver state
  int       hold_seen = 0;
  int       hold_left = 0;
  int       rx_cyc    = 0;
  rx_mode_t rx_mode   = RX_FREE;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  counting_semaphore_fifo_waitq i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_proc_id      (in_proc_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_woken_id    (out_woken_id),
    .out_count_now   (out_count_now),
    .out_waiters_now (out_waiters_now),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  semaphore_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_proc_id      (in_proc_id),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_woken_id    (out_woken_id),
    .out_count_now   (out_count_now),
    .out_waiters_now (out_waiters_now),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending_cnt     (pending_cnt),
    .fail_cnt        (fail_cnt),
    .status_seen     (status_seen)
  );

  // Receiver: keeps switching to a randomly chosen stall pattern; a hold request overrides it
  // with a long solid stall so the single in-flight beat backs up into in_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
      rx_cyc    <= 0;
      rx_mode   <= RX_FREE;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (rx_cyc % 64 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= rx_cyc[0];
        endcase
      end
    end
  end

  // Small id set so duplicates pile up in the queue and removes hit often.
  // Between them the entries set and clear every id bit.
  function automatic logic [ID_BITS-1:0] pool_id(input int k);
    case (k % 8)
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      3:       return 8'h80;
      4:       return 8'h5A;
      5:       return 8'hA5;
      6:       return 8'h3C;
      default: return 8'hC3;
    endcase
  endfunction

  // Present one request beat and hold it until taken. Called at a clock edge;
  // valid is left high so a following beat can go out back to back.
  task automatic offer(input logic [1:0] act, input logic [ID_BITS-1:0] id);
    in_valid   <= 1'b1;
    in_action  <= act;
    in_proc_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic go_idle(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sender stops until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write of a group.
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
  endtask

  // Random bursts of requests. Weights are percent; what is left over goes
  // to the no-op code. Most ids come from the pool, the rest are fully random.
  task automatic random_burst_run(input int n_items, input int w_wait, input int w_sig,
                                  input int w_rem);
    int                 left;
    int                 burst;
    int                 pick;
    logic [1:0]         act;
    logic [ID_BITS-1:0] id;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < w_wait)                     act = ACT_WAIT;
        else if (pick < w_wait + w_sig)        act = ACT_SIGNAL;
        else if (pick < w_wait + w_sig + w_rem) act = ACT_REMOVE;
        else                                   act = ACT_NOP;
        if ($urandom_range(0, 3) == 0) id = ID_BITS'($urandom);
        else                           id = pool_id($urandom_range(0, 7));
        offer(act, id);
        burst--;
        left--;
      end
      // Some bursts run straight into the next one
      if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 8));
    end
  endtask

  initial begin
    int i;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: count 0, ceiling 65535 out of reset
    offer(ACT_SIGNAL, 8'h00);   // empty queue: count goes 0 -> 1
    offer(ACT_WAIT, 8'hFF);     // unit available: granted
    offer(ACT_REMOVE, 8'h12);   // remove from an empty queue
    offer(ACT_NOP, 8'hC3);      // unused action code
    for (i = 0; i < QUEUE_DEPTH; i++) offer(ACT_WAIT, pool_id(i));  // fill the queue
    offer(ACT_WAIT, 8'h99);     // queue full: refused
    offer(ACT_REMOVE, pool_id(4));  // id queued twice: first copy goes
    offer(ACT_SIGNAL, 8'hFF);   // wakes the oldest waiter
    offer(ACT_REMOVE, 8'h42);   // no match in a non-empty queue
    // Units appear while waiters sit in the queue: the next wait is granted
    drain_results();
    reg_write(REG_INITIAL, 16'd2);
    cfg_valid <= 1'b0;
    offer(ACT_WAIT, 8'h11);

    // Default ceiling; wait-leaning mix fills the queue, then a long receiver
    // hold-off while the sender keeps offering, a full pause, a signal-heavy drain
    random_burst_run(200, 45, 35, 15);
    hold_req <= hold_req + 1;
    random_burst_run(60, 45, 35, 15);
    drain_results();
    random_burst_run(140, 25, 55, 15);

    // Ceiling 4: count saturates often. Load above the ceiling and a ceiling
    // below the count are both ignored.
    drain_results();
    reg_write(REG_INITIAL, 16'd0);
    reg_write(REG_MAX, 16'd4);
    reg_write(REG_INITIAL, 16'd2);
    reg_write(REG_INITIAL, 16'd9);
    reg_write(REG_MAX, 16'd1);
    cfg_valid <= 1'b0;
    random_burst_run(300, 30, 50, 15);

    // Top of the range: count and ceiling both 65535
    drain_results();
    reg_write(REG_MAX, 16'hFFFF);
    reg_write(REG_INITIAL, 16'hFFFF);
    cfg_valid <= 1'b0;
    random_burst_run(150, 30, 50, 15);

    // Ceiling 0: every wait queues or is refused; write to an unmapped index
    drain_results();
    reg_write(REG_INITIAL, 16'd0);
    reg_write(REG_MAX, 16'd0);
    reg_write(REG_UNMAPPED, 16'h1234);
    cfg_valid <= 1'b0;
    random_burst_run(300, 45, 35, 15);

    // Binary semaphore
    drain_results();
    reg_write(REG_MAX, 16'd1);
    reg_write(REG_INITIAL, 16'd1);
    cfg_valid <= 1'b0;
    random_burst_run(300, 40, 40, 15);

    // Mid-range count; an oversized load is refused first
    drain_results();
    reg_write(REG_MAX, 16'd1000);
    reg_write(REG_INITIAL, 16'hFFFF);
    reg_write(REG_INITIAL, 16'd300);
    cfg_valid <= 1'b0;
    random_burst_run(200, 40, 40, 15);

    // Wrap up: all results back, then a margin past the slowest remove
    drain_results();
    repeat (64) @(posedge clk);
    $display("Run covered %0d request beats and %0d register writes over six count/ceiling",
             beats_sent, cfg_writes);
    $display("settings; result status codes seen (bit per code): %b", status_seen[6:0]);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout at %0t with %0d results outstanding", $time, pending_cnt);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/csem_pkg.sv
src/csem_ram.sv
src/csem_queue.sv
src/counting_semaphore_fifo_waitq.sv
bench/semaphore_checker.sv
bench/tb_counting_semaphore_fifo_waitq.sv
